// File: hdl/annexb_nal_unit_delimiter_macros.svh
// Assertion helpers for the Annex B NAL unit delimiter.
// Both macros compile to nothing when SYNTH is defined.
`ifndef ANNEXB_NAL_UNIT_DELIMITER_MACROS_SVH
`define ANNEXB_NAL_UNIT_DELIMITER_MACROS_SVH

`ifndef SYNTH

// Checked on every rising edge while reset is released.
`define ANUD_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: check failed");

// Checked on every rising edge, reset or not.
`define ANUD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`else

`define ANUD_ASSERT(name, clk, rstn, prop)
`define ANUD_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// File: hdl/annexb_pkg.sv
package annexb_pkg;

  // Default width of the byte position counter.
  localparam int unsigned PosBitsDefault = 24;

  // Result field widths.
  localparam int unsigned StartW = 24;
  localparam int unsigned LenW   = 25;
  localparam int unsigned TypeW  = 6;

  // Three-byte window patterns.
  localparam logic [23:0] WinReset  = 24'hFF_FFFF;
  localparam logic [23:0] CodeOpen  = 24'h00_0001;
  localparam logic [23:0] CodeZero  = 24'h00_0000;

  // Codec selection.
  localparam logic CodecAvc  = 1'b0;
  localparam logic CodecHevc = 1'b1;

  // NAL unit type codes.
  localparam logic [TypeW-1:0] TypeHevcVps   = 6'd32;
  localparam logic [TypeW-1:0] TypeAvcSps    = 6'd7;
  localparam logic [TypeW-1:0] TypeHevcSps   = 6'd33;
  localparam logic [TypeW-1:0] TypeAvcPps    = 6'd8;
  localparam logic [TypeW-1:0] TypeHevcPps   = 6'd34;
  localparam logic [TypeW-1:0] TypeAvcIdr    = 6'd5;
  localparam logic [TypeW-1:0] TypeHevcIdrW  = 6'd19;
  localparam logic [TypeW-1:0] TypeHevcIdrN  = 6'd20;
  localparam logic [TypeW-1:0] TypeAvcSlcLo  = 6'd1;
  localparam logic [TypeW-1:0] TypeAvcSlcHi  = 6'd5;
  localparam logic [TypeW-1:0] TypeHevcSlcHi = 6'd31;

  // Classification flags of one unit.
  typedef struct packed {
    logic vps;
    logic sps;
    logic pps;
    logic idr;
    logic slice;
  } nal_class_t;

  // Unit type from the header byte.
  function automatic logic [TypeW-1:0] header_type(input logic codec, input logic [7:0] hdr);
    logic [TypeW-1:0] t;
    if (codec == CodecHevc) begin
      t = hdr[6:1];
    end else begin
      t = {1'b0, hdr[4:0]};
    end
    return t;
  endfunction

  // Class flags of a type under the given codec rules.
  function automatic nal_class_t classify(input logic codec, input logic [TypeW-1:0] t);
    nal_class_t c;
    c.vps = (t == TypeHevcVps);
    if (codec == CodecHevc) begin
      c.sps   = (t == TypeHevcSps);
      c.pps   = (t == TypeHevcPps);
      c.idr   = (t == TypeHevcIdrW) || (t == TypeHevcIdrN);
      c.slice = (t <= TypeHevcSlcHi);
    end else begin
      c.sps   = (t == TypeAvcSps);
      c.pps   = (t == TypeAvcPps);
      c.idr   = (t == TypeAvcIdr);
      c.slice = (t >= TypeAvcSlcLo) && (t <= TypeAvcSlcHi);
    end
    return c;
  endfunction

endpackage

// File: hdl/annexb_nal_unit_delimiter.sv
// Annex B NAL unit delimiter. Takes an AVC or HEVC Annex B byte stream one
// byte per transaction (last_byte_i marks the final byte of a buffer) and
// returns one transaction per NAL unit found: its start position in the
// buffer, its length without start code, its type and class flags, and
// whether the end of the buffer cut it. A 00 00 01 opens a unit; a later
// 00 00 00 or 00 00 01 closes it, and a closing 00 00 01 opens the next.
// Throughput is one byte per clock while in_stall_o is low: each byte is
// parsed in the cycle it is accepted and any result lands in an output
// register, shown from the cycle after its byte. in_stall_o is high only
// while a result is held and out_stall_i is high.
// codec_select (cfg_wdata_i) picks AVC (0) or HEVC (1) header rules and is
// to be written by the user only while the block is idle; the block itself
// does not enforce this. Positions saturate at 2^POS_BITS - 1; after the
// last byte of a buffer the parser starts over at position 0.
`include "annexb_nal_unit_delimiter_macros.svh"

module annexb_nal_unit_delimiter
  import annexb_pkg::*;
#(
  parameter int unsigned POS_BITS = PosBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  // byte input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  // unit results
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [StartW-1:0] unit_start_o,
  output logic [LenW-1:0]   nal_length_o,
  output logic [TypeW-1:0]  nal_type_o,
  output logic              is_vps_o,
  output logic              is_sps_o,
  output logic              is_pps_o,
  output logic              is_idr_o,
  output logic              is_slice_o,
  output logic              cut_by_end_o
);

  localparam logic [POS_BITS-1:0] PosMax = {POS_BITS{1'b1}};

  // configuration register
  logic codec_select_q;

  // parser state
  logic [23:0]         win_q, win_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic                inside_q, inside_d;
  logic [POS_BITS-1:0] start_q, start_d;
  logic                pend_q, pend_d;
  logic [TypeW-1:0]    type_q, type_d;

  // result register
  logic                out_valid_q, out_valid_d;
  logic [StartW-1:0]   res_start_q;
  logic [LenW-1:0]     res_len_q;
  logic [TypeW-1:0]    res_type_q;
  nal_class_t          res_class_q;
  logic                res_cut_q;

  logic                in_accept;
  logic                hdr_now;
  logic [TypeW-1:0]    type_cur;
  logic                pend_cur;
  logic                open_code, zero_code;
  logic                close_code, close_last, emit;
  logic [POS_BITS-1:0] pos_next;
  logic [POS_BITS:0]   end_ext, start_ext, len_ext;
  logic                unit_ok;
  logic [TypeW-1:0]    emit_type;
  nal_class_t          emit_class;

  // the result register is free unless it holds a stalled result
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    // header byte directly after the start code
    hdr_now  = inside_q && pend_q;
    type_cur = hdr_now ? header_type(codec_select_q, data_byte_i) : type_q;
    pend_cur = pend_q && !hdr_now;

    win_d     = {win_q[15:0], data_byte_i};
    open_code = (win_d == CodeOpen);
    zero_code = (win_d == CodeZero);

    close_code = inside_q && (open_code || zero_code);
    close_last = inside_q && last_byte_i && !close_code;
    emit       = close_code || close_last;

    pos_next = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;

    // unit ends before the closing pattern, or after this byte at buffer end
    if (close_code) begin
      end_ext = (pos_q >= POS_BITS'(2)) ? {1'b0, pos_q - POS_BITS'(2)} : '0;
    end else begin
      end_ext = {1'b0, pos_q} + 1'b1;
    end
    start_ext = {1'b0, start_q};
    len_ext   = (end_ext > start_ext) ? (end_ext - start_ext) : '0;

    // an empty unit has no header byte of its own
    unit_ok    = (len_ext != '0) && !pend_cur;
    emit_type  = unit_ok ? type_cur : '0;
    emit_class = unit_ok ? classify(codec_select_q, emit_type) : '0;

    // next parser state
    if (last_byte_i) begin
      win_d    = WinReset;
      pos_d    = '0;
      inside_d = 1'b0;
      start_d  = '0;
      pend_d   = 1'b0;
      type_d   = '0;
    end else if (open_code) begin
      pos_d    = pos_next;
      inside_d = 1'b1;
      start_d  = pos_next;
      pend_d   = 1'b1;
      type_d   = '0;
    end else begin
      pos_d    = pos_next;
      inside_d = inside_q && !emit;
      start_d  = start_q;
      pend_d   = pend_cur;
      type_d   = type_cur;
    end

    // accept implies the result register is free this cycle
    if (in_accept) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_select_q <= CodecAvc;
    end else if (cfg_we_i) begin
      codec_select_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= WinReset;
      pos_q    <= '0;
      inside_q <= 1'b0;
      start_q  <= '0;
      pend_q   <= 1'b0;
      type_q   <= '0;
    end else if (in_accept) begin
      win_q    <= win_d;
      pos_q    <= pos_d;
      inside_q <= inside_d;
      start_q  <= start_d;
      pend_q   <= pend_d;
      type_q   <= type_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      res_start_q <= StartW'(start_q);
      res_len_q   <= LenW'(len_ext);
      res_type_q  <= emit_type;
      res_class_q <= emit_class;
      res_cut_q   <= close_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign unit_start_o = res_start_q;
  assign nal_length_o = res_len_q;
  assign nal_type_o   = res_type_q;
  assign is_vps_o     = res_class_q.vps;
  assign is_sps_o     = res_class_q.sps;
  assign is_pps_o     = res_class_q.pps;
  assign is_idr_o     = res_class_q.idr;
  assign is_slice_o   = res_class_q.slice;
  assign cut_by_end_o = res_cut_q;

  // header can only be awaited inside a unit
  `ANUD_ASSERT(a_pend_inside, clk_i, rst_ni, (!pend_q || inside_q))

  // an open unit never starts past the current position
  `ANUD_ASSERT(a_start_le_pos, clk_i, rst_ni, (inside_q |-> (start_q <= pos_q)))

  // the last byte of a buffer returns the parser to its start
  `ANUD_ASSERT(a_buffer_end, clk_i, rst_ni,
               ((in_accept && last_byte_i) |=> ((pos_q == '0) && !inside_q)))

  // position advances by one per byte until it saturates
  `ANUD_ASSERT(a_pos_step, clk_i, rst_ni,
               ((in_accept && !last_byte_i && (pos_q != PosMax)) |=>
                (pos_q == $past(pos_q) + 1'b1)))

endmodule
